// File: rtl/core/tcaf_pkg.sv
// Shared constants, codes and types for the two-class age-ordered FIFO.
package tcaf_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF     = 16;
	localparam int ID_FIELD_BITS   = 16;
	localparam int STAMP_BITS      = 16;

	typedef enum logic [1:0] {
		REQ_ENQUEUE = 2'd0,
		REQ_DEQ_ANY = 2'd1,
		REQ_DEQ_C0  = 2'd2,
		REQ_DEQ_C1  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic push;
		logic pop;
	} qptr_ctrl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qptr_stat_t;

endpackage

// File: rtl/core/tcaf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tcaf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/tcaf_qptr.sv
// Head, tail and fill count of one class queue.
module tcaf_qptr
	import tcaf_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  qptr_ctrl_t                     ctrl,
	output qptr_stat_t                     stat,
	output logic [$clog2(QUEUE_DEPTH)-1:0] head,
	output logic [$clog2(QUEUE_DEPTH)-1:0] tail
);

	localparam int PtrW = $clog2(QUEUE_DEPTH);
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

	logic [PtrW-1:0] head_q, tail_q;
	logic [CntW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctrl.push) begin
				tail_q <= (tail_q == LastPtr) ? '0 : tail_q + 1'b1;
			end
			if (ctrl.pop) begin
				head_q <= (head_q == LastPtr) ? '0 : head_q + 1'b1;
			end
			if (ctrl.push && !ctrl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.pop && !ctrl.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == FullCnt);
	assign head = head_q;
	assign tail = tail_q;

endmodule

// File: rtl/core/two_class_age_ordered_fifo.sv
// Top level of the two-class age-ordered FIFO.
// A request waits in a decision stage before its result is registered: the head entries
// of both class queues are read from their RAMs at acceptance, and the decision, pointer
// update and enqueue write happen in the decision stage, from the registered read data, once
// the output register is free or being taken. The next request is accepted in the cycle after
// that decision, so no request is taken before the last one is decided. A finished result
// waits in an output register; while it is not taken, one more request can be accepted and
// then waits in the decision stage, which holds off further input. Every request gives one
// result: status is done, empty or full, and the class, id and arrival stamp of a dequeued
// item (all zero otherwise). Stamps come from a 16-bit counter that advances on each
// successful enqueue and are compared modulo wrap.
module two_class_age_ordered_fifo
	import tcaf_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = ID_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               req_type,
	input  logic                     item_class,
	input  logic [ID_FIELD_BITS-1:0] item_id,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic                     out_class,
	output logic [ID_FIELD_BITS-1:0] out_id,
	output logic [STAMP_BITS-1:0]    out_stamp
);

	localparam int PtrW  = $clog2(QUEUE_DEPTH);
	localparam int IdW   = (ID_BITS < ID_FIELD_BITS) ? ID_BITS : ID_FIELD_BITS;
	localparam int EntW  = IdW + STAMP_BITS;

	logic            accept;
	logic            fire;
	logic            valid_s1;
	req_t            req_s1;
	logic            cls_s1;
	logic [IdW-1:0]  id_s1;
	logic [STAMP_BITS-1:0] next_stamp_q;

	qptr_ctrl_t      ctrl [2];
	qptr_stat_t      stat [2];
	logic [PtrW-1:0] head [2];
	logic [PtrW-1:0] tail [2];
	logic [EntW-1:0] rdata [2];
	logic [EntW-1:0] wdata;

	logic            out_valid_q;
	status_t         status_q;
	logic            out_class_q;
	logic [IdW-1:0]  out_id_q;
	logic [STAMP_BITS-1:0] out_stamp_q;

	status_t         res_status;
	logic            pick;
	logic            do_pop;
	logic            do_push;
	logic [STAMP_BITS-1:0] stamp_diff;

	assign in_ready = !valid_s1;
	assign accept   = in_valid && in_ready;
	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign wdata    = {id_s1, next_stamp_q};

	for (genvar c = 0; c < 2; c++) begin : g_class
		tcaf_qptr #(
			.QUEUE_DEPTH(QUEUE_DEPTH)
		) u_qptr (
			.clk   (clk),
			.arst_n(arst_n),
			.ctrl  (ctrl[c]),
			.stat  (stat[c]),
			.head  (head[c]),
			.tail  (tail[c])
		);

		tcaf_ram #(
			.WIDTH(EntW),
			.DEPTH(QUEUE_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (ctrl[c].push),
			.waddr(tail[c]),
			.wdata(wdata),
			.re   (accept),
			.raddr(head[c]),
			.rdata(rdata[c])
		);

		assign ctrl[c].push = fire && do_push && (cls_s1 == 1'(c));
		assign ctrl[c].pop  = fire && do_pop && (pick == 1'(c));
	end

	// Class 0 is older when its stamp minus the class 1 stamp is negative modulo wrap.
	assign stamp_diff = rdata[0][STAMP_BITS-1:0] - rdata[1][STAMP_BITS-1:0];

	always_comb begin
		res_status = STATUS_DONE;
		pick       = 1'b0;
		do_pop     = 1'b0;
		do_push    = 1'b0;
		case (req_s1)
			REQ_ENQUEUE: begin
				if (stat[cls_s1].full) begin
					res_status = STATUS_FULL;
				end else begin
					do_push = 1'b1;
				end
			end
			REQ_DEQ_ANY: begin
				if (stat[0].empty && stat[1].empty) begin
					res_status = STATUS_EMPTY;
				end else begin
					do_pop = 1'b1;
					if (stat[0].empty) begin
						pick = 1'b1;
					end else if (stat[1].empty) begin
						pick = 1'b0;
					end else begin
						pick = !stamp_diff[STAMP_BITS-1];
					end
				end
			end
			REQ_DEQ_C0, REQ_DEQ_C1: begin
				pick = (req_s1 == REQ_DEQ_C1);
				if (stat[pick].empty) begin
					res_status = STATUS_EMPTY;
				end else begin
					do_pop = 1'b1;
				end
			end
			default: begin
				res_status = STATUS_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			next_stamp_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire && do_push) begin
				next_stamp_q <= next_stamp_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_t'(req_type);
			cls_s1 <= item_class;
			id_s1  <= item_id[IdW-1:0];
		end
		if (fire) begin
			status_q <= res_status;
			if (do_pop) begin
				out_class_q <= pick;
				out_id_q    <= rdata[pick][EntW-1:STAMP_BITS];
				out_stamp_q <= rdata[pick][STAMP_BITS-1:0];
			end else begin
				out_class_q <= 1'b0;
				out_id_q    <= '0;
				out_stamp_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_class = out_class_q;
	assign out_id    = ID_FIELD_BITS'(out_id_q);
	assign out_stamp = out_stamp_q;

endmodule
